[design/sorted_integer_set_table_top_defines.svh]
// Assertion macros for the sorted integer set table checker.
`ifndef SORTED_INTEGER_SET_TABLE_TOP_DEFINES_SVH
`define SORTED_INTEGER_SET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SIST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sist_pkg.sv]
// Shared types and codes for the sorted integer set table.
package sist_pkg;

  localparam int KEY_W = 32;

  // Operation codes
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_ERASE_VAL = 3'd1;
  localparam logic [2:0] OP_ERASE_POS = 3'd2;
  localparam logic [2:0] OP_FIND      = 3'd3;
  localparam logic [2:0] OP_FLOOR     = 3'd4;
  localparam logic [2:0] OP_CEIL      = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Compare unit result
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

[design/sorted_integer_set_table_top.sv]
// Sorted integer set table: sequencer over one table (one write and one read port) and one shared comparator.
// Clear, unused codes and early errors finish at decode; lookups scan and then act, erase by
// position captures the element and shifts down, insert scans and shifts up, erase by value
// scans and shifts down; the work grows with the held count. out_valid pulses one cycle.
// Busy drops with the result beat, so a new operation can start on that edge; one is in flight at a time.
// Synchronous active-low reset empties the set; table contents are not cleared.
module sorted_integer_set_table_top import sist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_operation,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic [5:0]              in_slot_index,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic                    out_hit,
  output logic [5:0]              out_where_found,
  output logic signed [KEY_W-1:0] out_element_out,
  output logic [6:0]              out_member_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_ACT    = 3'd3;
  localparam logic [2:0] S_CAPT   = 3'd4;
  localparam logic [2:0] S_SHUP   = 3'd5;
  localparam logic [2:0] S_SHDN   = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    dv_r, dv_nxt;
  logic                    ov_r, ov_nxt;
  logic [CW-1:0]           p_r, p_nxt;
  logic [AW-1:0]           wa_r, wa_nxt;
  logic [CW-1:0]           lb_r, lb_nxt;
  logic                    eq_r, eq_nxt;
  logic [KEY_W-1:0]        lbval_r, lbval_nxt;
  logic [KEY_W-1:0]        prev_r, prev_nxt;
  logic [2:0]              op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [5:0]              slot_r, slot_nxt;
  logic [2:0]              st_r, st_nxt;
  logic                    hit_r, hit_nxt;
  logic [CW-1:0]           where_r, where_nxt;
  logic [KEY_W-1:0]        elem_r, elem_nxt;
  logic [6:0]              mcnt_r, mcnt_nxt;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [KEY_W-1:0]        wdata;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rd_data;
  cmp_t                    cmp;

  logic [31:0]             slot_ext;
  logic [31:0]             cnt_ext;
  logic [31:0]             cnt_nxt_ext;
  logic [31:0]             where_ext;
  logic [CW-1:0]           pm1;
  logic                    lbin;
  logic                    hit_eq;

  sist_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  sist_cmp u_cmp (
    .a   (rd_data),
    .b   (key_r),
    .res (cmp)
  );

  assign slot_ext  = 32'(slot_r);
  assign cnt_ext   = 32'(cnt_r);
  assign where_ext = 32'(where_r);
  assign pm1       = p_r - CW'(1);
  assign lbin      = lb_r < cnt_r;
  assign hit_eq    = lbin && eq_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = dv_r;
    ov_nxt    = 1'b0;
    p_nxt     = p_r;
    wa_nxt    = wa_r;
    lb_nxt    = lb_r;
    eq_nxt    = eq_r;
    lbval_nxt = lbval_r;
    prev_nxt  = prev_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    slot_nxt  = slot_r;
    st_nxt    = st_r;
    hit_nxt   = hit_r;
    where_nxt = where_r;
    elem_nxt  = elem_r;
    mcnt_nxt  = mcnt_r;
    raddr     = p_r[AW-1:0];
    we        = 1'b0;
    waddr     = wa_r;
    wdata     = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          key_nxt   = in_key_value;
          slot_nxt  = in_slot_index;
          state_nxt = S_DISP;
        end
      end

      // Decode; early outcomes finish here
      S_DISP: begin
        st_nxt    = ST_OK;
        hit_nxt   = 1'b0;
        where_nxt = '0;
        elem_nxt  = '0;
        p_nxt     = '0;
        dv_nxt    = 1'b0;
        raddr     = slot_ext[AW-1:0];
        case (op_r) inside
          OP_INSERT: begin
            state_nxt = S_SEARCH;
          end
          OP_ERASE_VAL, OP_FIND, OP_FLOOR, OP_CEIL: begin
            if (cnt_r == '0) begin
              st_nxt    = ST_EMPTY;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
          OP_ERASE_POS: begin
            if (cnt_r == '0) begin
              st_nxt    = ST_EMPTY;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else if (slot_ext >= cnt_ext) begin
              st_nxt    = ST_BADPOS;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              lb_nxt    = slot_ext[CW-1:0];
              state_nxt = S_CAPT;
            end
          end
          OP_CLEAR: begin
            cnt_nxt   = '0;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Linear scan for the first element not below the key, one read per cycle
      S_SEARCH: begin
        if (dv_r && !cmp.lt) begin
          lb_nxt    = pm1;
          lbval_nxt = rd_data;
          eq_nxt    = cmp.eq;
          state_nxt = S_ACT;
        end else begin
          if (dv_r) begin
            prev_nxt = rd_data;
          end
          if (p_r == cnt_r) begin
            lb_nxt    = cnt_r;
            eq_nxt    = 1'b0;
            state_nxt = S_ACT;
          end else begin
            p_nxt  = p_r + CW'(1);
            dv_nxt = 1'b1;
          end
        end
      end

      // Act on the search outcome
      S_ACT: begin
        dv_nxt = 1'b0;
        case (op_r) inside
          OP_INSERT: begin
            if (hit_eq) begin
              st_nxt    = ST_DUP;
              hit_nxt   = 1'b1;
              where_nxt = lb_r;
              elem_nxt  = key_r;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else if (cnt_r == CW'(CAPACITY)) begin
              st_nxt    = ST_FULL;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              where_nxt = lb_r;
              elem_nxt  = key_r;
              p_nxt     = cnt_r;
              state_nxt = S_SHUP;
            end
          end
          OP_ERASE_VAL: begin
            if (hit_eq) begin
              hit_nxt   = 1'b1;
              where_nxt = lb_r;
              elem_nxt  = key_r;
              p_nxt     = lb_r + CW'(1);
              state_nxt = S_SHDN;
            end else begin
              st_nxt    = ST_NOTFOUND;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          OP_FIND: begin
            if (hit_eq) begin
              hit_nxt   = 1'b1;
              where_nxt = lb_r;
              elem_nxt  = key_r;
            end else begin
              st_nxt = ST_NOTFOUND;
            end
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_FLOOR: begin
            if (hit_eq) begin
              hit_nxt   = 1'b1;
              where_nxt = lb_r;
              elem_nxt  = key_r;
            end else if (lb_r != '0) begin
              hit_nxt   = 1'b1;
              where_nxt = lb_r - CW'(1);
              elem_nxt  = prev_r;
            end else begin
              st_nxt = ST_NOTFOUND;
            end
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            // ceiling
            if (lbin) begin
              hit_nxt   = 1'b1;
              where_nxt = lb_r;
              elem_nxt  = lbval_r;
            end else begin
              st_nxt = ST_NOTFOUND;
            end
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Element at the erase position, read during decode
      S_CAPT: begin
        hit_nxt   = 1'b1;
        where_nxt = lb_r;
        elem_nxt  = rd_data;
        p_nxt     = lb_r + CW'(1);
        dv_nxt    = 1'b0;
        state_nxt = S_SHDN;
      end

      // Open a gap: move entries up from the top, then drop the key in
      S_SHUP: begin
        we = dv_r;
        if (p_r > lb_r) begin
          raddr  = pm1[AW-1:0];
          wa_nxt = p_r[AW-1:0];
          dv_nxt = 1'b1;
          p_nxt  = pm1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            we        = 1'b1;
            waddr     = lb_r[AW-1:0];
            wdata     = key_r;
            cnt_nxt   = cnt_r + CW'(1);
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      // Close the gap: move entries down toward the erased position
      S_SHDN: begin
        we = dv_r;
        if (p_r < cnt_r) begin
          raddr  = p_r[AW-1:0];
          wa_nxt = pm1[AW-1:0];
          dv_nxt = 1'b1;
          p_nxt  = p_r + CW'(1);
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Count reported with the result beat
    cnt_nxt_ext = 32'(cnt_nxt);
    if (ov_nxt) begin
      mcnt_nxt = cnt_nxt_ext[6:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    wa_r    <= wa_nxt;
    lb_r    <= lb_nxt;
    eq_r    <= eq_nxt;
    lbval_r <= lbval_nxt;
    prev_r  <= prev_nxt;
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    slot_r  <= slot_nxt;
    st_r    <= st_nxt;
    hit_r   <= hit_nxt;
    where_r <= where_nxt;
    elem_r  <= elem_nxt;
    mcnt_r  <= mcnt_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_hit          = hit_r;
  assign out_where_found  = where_ext[5:0];
  assign out_element_out  = elem_r;
  assign out_member_count = mcnt_r;

endmodule

[design/sist_store.sv]
// Element table: one write port, one read port with registered read data.
module sist_store import sist_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem_r [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/sist_cmp.sv]
// Shared signed compare unit: table element against the key.
module sist_cmp import sist_pkg::*; (
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output cmp_t                    res
);

  // a below b, a equal to b
  always_comb begin
    res.lt = a < b;
    res.eq = a == b;
  end

endmodule

[design/sist_chk.sv]
// Port-level checker for the sorted integer set table, bound to the top level.
`include "sorted_integer_set_table_top_defines.svh"

module sist_chk import sist_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_hit,
  input logic [6:0] out_member_count
);

  logic accept;
  logic hit_ok;
  logic empty_ok;

  assign accept   = start && !busy;
  assign hit_ok   = out_status == ST_OK || out_status == ST_DUP;
  assign empty_ok = out_member_count == 7'd0 && !out_hit;

  // Result beat only once the block is free again
  `SIST_ASSERT_NOW(a_res_idle, out_valid, !busy, "result beat while busy")

  // Every accepted operation is followed by busy, with no result beat yet
  `SIST_ASSERT_NEXT(a_acc_busy, accept, busy && !out_valid, "accepted op not busy next cycle")

  // A hit is either a success or a duplicate insert
  `SIST_ASSERT_NOW(a_hit_status, out_valid && out_hit, hit_ok, "hit with error status")

  // Empty status only with an empty set and no hit
  `SIST_ASSERT_NOW(a_empty, out_valid && out_status == ST_EMPTY, empty_ok, "empty with members")

endmodule

bind sorted_integer_set_table_top sist_chk u_sist_chk (.*);
